// File: hdl/sma_pkg.sv
// Shared types and constants for the seeded moving average block.
// Used by the controller, the datapath and the top level.
package sma_pkg;

    localparam int SMA_MAX_WINDOW  = 256;
    localparam int SMA_SAMPLE_BITS = 32;
    localparam int LEN_W           = 9;
    localparam int DIVR_W          = LEN_W + 1;
    localparam int ADDR_W          = 3;

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_LEN  = 1'b1;

    localparam logic [LEN_W-1:0] LEN_RESET = 9'd1;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_RUN  = 2'd1,
        PH_STOP = 2'd2
    } phase_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CLASS  = 6'b000010,
        ST_WIN    = 6'b000100,
        ST_SUMCHK = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    typedef struct packed {
        logic load;
        logic classify;
        logic win_upd;
        logic div_start;
        logic div_ema;
        logic div_take;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic go_none;
        logic go_ema;
        logic seen_full;
        logic div_done;
    } status_t;

endpackage

// File: hdl/sma_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
module sma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/sma_div.sv
// Radix-2 restoring signed-by-unsigned divider, truncating toward zero.
// One quotient bit per cycle. No dependencies.
module sma_div #(
    parameter int DW = 41,
    parameter int VW = 10
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic          neg_reg, neg_next;
    logic [VW:0]   rem_sh;
    logic [VW:0]   rem_sub;
    logic          ge;

    always_comb begin
        rem_sh    = {rem_reg, quo_reg[DW-1]};
        rem_sub   = rem_sh - {1'b0, dvs_reg};
        ge        = (rem_sh >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start) begin
            neg_next  = dividend[DW-1];
            quo_next  = dividend[DW-1] ? (~dividend + DW'(1)) : dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
            quo_next = {quo_reg[DW-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + DW'(1)) : quo_reg;

endmodule

// File: hdl/sma_ctrl.sv
// Sequencing state machine for the seeded moving average block.
// Depends on sma_pkg; drives the datapath through sma_pkg::cmd_t.
module sma_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  sma_pkg::status_t st,
    output sma_pkg::cmd_t    cmd
);
    sma_pkg::state_t state_reg, state_next;
    logic            m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            sma_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = sma_pkg::ST_CLASS;
                end
            end
            sma_pkg::ST_CLASS: begin
                cmd.classify = 1'b1;
                if (st.go_none) begin
                    state_next = sma_pkg::ST_DONE;
                end else if (st.go_ema) begin
                    cmd.div_start = 1'b1;
                    cmd.div_ema   = 1'b1;
                    state_next    = sma_pkg::ST_DIV;
                end else begin
                    state_next = sma_pkg::ST_WIN;
                end
            end
            sma_pkg::ST_WIN: begin
                cmd.win_upd = 1'b1;
                state_next  = sma_pkg::ST_SUMCHK;
            end
            sma_pkg::ST_SUMCHK: begin
                if (st.seen_full) begin
                    cmd.div_start = 1'b1;
                    state_next    = sma_pkg::ST_DIV;
                end else begin
                    state_next = sma_pkg::ST_DONE;
                end
            end
            sma_pkg::ST_DIV: begin
                if (st.div_done) begin
                    cmd.div_take = 1'b1;
                    state_next   = sma_pkg::ST_DONE;
                end
            end
            sma_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.emit   = 1'b1;
                    state_next = sma_pkg::ST_IDLE;
                end
            end
            default: state_next = sma_pkg::ST_IDLE;
        endcase
        m_tvalid_next = cmd.emit ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sma_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == sma_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

`ifndef SYNTHESIS
    a_accept_to_class: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == sma_pkg::ST_CLASS))
        else $error("accepted transaction did not enter classification");
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        st.div_done |-> (state_reg == sma_pkg::ST_DIV))
        else $error("divider finished outside the divide state");
`endif

endmodule

// File: hdl/sma_dpath.sv
// Datapath: series state, window ring, running sum, EMA value and divider.
// Depends on sma_pkg, sma_ram and sma_div.
module sma_dpath #(
    parameter int MAX_WINDOW  = sma_pkg::SMA_MAX_WINDOW,
    parameter int SAMPLE_BITS = sma_pkg::SMA_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sma_pkg::cmd_t                 cmd,
    output sma_pkg::status_t              st,
    input  logic                          cfg_clear,
    input  logic                          average_mode,
    input  logic [sma_pkg::LEN_W-1:0]     window_length,
    input  logic [SAMPLE_BITS-1:0]        in_sample,
    input  logic                          in_finite,
    input  logic                          in_start,
    output logic [SAMPLE_BITS-1:0]        out_average,
    output logic                          out_valid
);
    localparam int SB = SAMPLE_BITS;
    localparam int LW = sma_pkg::LEN_W;
    localparam int VW = sma_pkg::DIVR_W;
    localparam int DW = SB + LW;
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int PW = ((AW > LW) ? AW : LW) + 1;

    logic [SB-1:0]    x_reg;
    logic             fin_reg;
    sma_pkg::phase_t  phase_reg, phase_next;
    logic [LW-1:0]    seen_reg, seen_next;
    logic [AW-1:0]    wp_reg, wp_next;
    logic [DW-1:0]    sum_reg, sum_next;
    logic [SB-1:0]    sm_reg, sm_next;
    logic [SB-1:0]    res_reg, res_next;
    logic             res_valid_reg, res_valid_next;
    logic             div_ema_reg;
    logic [SB-1:0]    m_avg_reg;
    logic             m_valid_reg;

    logic [LW-1:0]    eff_p;
    logic             seen_ge;
    logic [SB-1:0]    ram_rdata;
    logic [DW-1:0]    old_ext;
    logic [DW-1:0]    x_ext;
    logic [SB:0]      ema_diff;
    logic [DW-1:0]    div_dividend;
    logic [VW-1:0]    div_divisor;
    logic             div_done;
    logic [DW-1:0]    div_quot;
    logic [SB-1:0]    sm_ema;

    assign eff_p   = (32'(window_length) > 32'(MAX_WINDOW)) ? LW'(MAX_WINDOW) : window_length;
    assign seen_ge = (seen_reg >= eff_p);

    assign st.go_none   = (eff_p == '0) || (phase_reg == sma_pkg::PH_STOP) || !fin_reg;
    assign st.go_ema    = average_mode && seen_ge;
    assign st.seen_full = seen_ge;
    assign st.div_done  = div_done;

    assign x_ext    = {{(DW-SB){x_reg[SB-1]}}, x_reg};
    assign old_ext  = seen_ge ? {{(DW-SB){ram_rdata[SB-1]}}, ram_rdata} : '0;
    assign ema_diff = {x_reg[SB-1], x_reg} - {sm_reg[SB-1], sm_reg};

    assign div_dividend = cmd.div_ema ? {{(DW-SB-2){ema_diff[SB]}}, ema_diff, 1'b0} : sum_reg;
    assign div_divisor  = cmd.div_ema ? ({1'b0, eff_p} + VW'(1)) : {1'b0, eff_p};
    assign sm_ema       = sm_reg + div_quot[SB-1:0];

    sma_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .aclk  (aclk),
        .we    (cmd.win_upd),
        .waddr (wp_reg),
        .wdata (x_reg),
        .re    (cmd.classify),
        .raddr (wp_reg),
        .rdata (ram_rdata)
    );

    sma_div #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb begin
        phase_next     = phase_reg;
        seen_next      = seen_reg;
        wp_next        = wp_reg;
        sum_next       = sum_reg;
        sm_next        = sm_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (cfg_clear || (cmd.load && in_start)) begin
            phase_next = sma_pkg::PH_WAIT;
            seen_next  = '0;
            wp_next    = '0;
            sum_next   = '0;
            sm_next    = '0;
        end
        if (cmd.load) begin
            res_next       = '0;
            res_valid_next = 1'b0;
        end
        if (cmd.classify) begin
            if (!st.go_none) begin
                phase_next = sma_pkg::PH_RUN;
            end else if (eff_p != '0 && !fin_reg && phase_reg == sma_pkg::PH_RUN) begin
                phase_next = sma_pkg::PH_STOP;
            end
        end
        if (cmd.win_upd) begin
            sum_next = sum_reg - old_ext + x_ext;
            wp_next  = (PW'(wp_reg) + PW'(1) == PW'(eff_p)) ? '0 : wp_reg + AW'(1);
            if (!seen_ge) begin
                seen_next = seen_reg + LW'(1);
            end
        end
        if (cmd.div_take) begin
            res_valid_next = 1'b1;
            if (div_ema_reg) begin
                sm_next  = sm_ema;
                res_next = sm_ema;
            end else begin
                sm_next  = div_quot[SB-1:0];
                res_next = div_quot[SB-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= sma_pkg::PH_WAIT;
            seen_reg      <= '0;
            wp_reg        <= '0;
            sum_reg       <= '0;
            sm_reg        <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            seen_reg      <= seen_next;
            wp_reg        <= wp_next;
            sum_reg       <= sum_next;
            sm_reg        <= sm_next;
            res_valid_reg <= res_valid_next;
        end
        res_reg <= res_next;
        if (cmd.load) begin
            x_reg   <= in_sample;
            fin_reg <= in_finite;
        end
        if (cmd.div_start) begin
            div_ema_reg <= cmd.div_ema;
        end
        if (cmd.emit) begin
            m_avg_reg   <= res_valid_reg ? res_reg : '0;
            m_valid_reg <= res_valid_reg;
        end
    end

    assign out_average = m_avg_reg;
    assign out_valid   = m_valid_reg;

`ifndef SYNTHESIS
    a_seen_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg <= eff_p)
        else $error("sample count exceeds the window length");
    a_valid_only_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && res_valid_reg) |-> (phase_reg == sma_pkg::PH_RUN))
        else $error("valid average emitted outside a running series");
`endif

endmodule

// File: hdl/seeded_moving_average.sv
// Seeded moving average: streaming SMA or SMA-seeded EMA over signed samples.
// Channels: s_tdata carries the sample (Q16.16 at 32 bits); s_tuser[0] is the
// finite flag, s_tuser[1] marks the first sample of a series. Every accepted
// transaction yields exactly one result transaction: m_tdata carries the
// average, m_tuser[0] says whether it is defined (a zero average otherwise).
// The APB port holds average_mode at 0x0 and window_length at 0x4; any write
// restarts the series. Write only while no transaction is in flight.
// Sequencing: one transaction at a time. A sample that yields no average goes
// from classification straight to the output stage; one that only fills the
// window passes the ring update and the sum check first. An average needs the
// one-bit-per-cycle divider over SAMPLE_BITS + 9 bits: an EMA step enters it
// from classification, a window mean after the ring update and sum check.
// The result sits in an output register, so the next sample is taken while
// the previous result waits; a stalled receiver holds m_tvalid and data, and
// the block stalls only once a second result is ready.
// Reset (aresetn low, synchronous) returns mode to SMA, window to 1 and the
// series to its waiting phase; the window ring needs no clearing pass.
// Depends on sma_pkg, sma_ctrl and sma_dpath.
module seeded_moving_average #(
    parameter int MAX_WINDOW  = sma_pkg::SMA_MAX_WINDOW,
    parameter int SAMPLE_BITS = sma_pkg::SMA_SAMPLE_BITS,
    localparam int TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // sample
    input  logic [TDATA_W-1:0]            s_tdata,
    // [0] sample_finite, [1] series_start
    input  logic [1:0]                    s_tuser,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // average
    output logic [TDATA_W-1:0]            m_tdata,
    // [0] average_valid
    output logic [0:0]                    m_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sma_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    localparam int LW      = sma_pkg::LEN_W;

    logic                  mode_reg, mode_next;
    logic [LW-1:0]         len_reg, len_next;
    logic                  cfg_wr;
    logic                  reg_idx;
    sma_pkg::cmd_t         cmd;
    sma_pkg::status_t      st;
    logic [SAMPLE_BITS-1:0] avg;
    logic                  avg_valid;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_comb begin
        mode_next = mode_reg;
        len_next  = len_reg;
        prdata    = '0;
        unique case (reg_idx)
            sma_pkg::REG_MODE: begin
                prdata = {31'b0, mode_reg};
                if (cfg_wr) begin
                    mode_next = pwdata[0];
                end
            end
            sma_pkg::REG_LEN: begin
                prdata = {{(32-LW){1'b0}}, len_reg};
                if (cfg_wr) begin
                    len_next = pwdata[LW-1:0];
                end
            end
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            len_reg  <= sma_pkg::LEN_RESET;
        end else begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
        end
    end

    sma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    sma_dpath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .st            (st),
        .cfg_clear     (cfg_wr),
        .average_mode  (mode_reg),
        .window_length (len_reg),
        .in_sample     (s_tdata[SAMPLE_BITS-1:0]),
        .in_finite     (s_tuser[0]),
        .in_start      (s_tuser[1]),
        .out_average   (avg),
        .out_valid     (avg_valid)
    );

    assign m_tdata    = TDATA_W'(avg);
    assign m_tuser[0] = avg_valid;

endmodule
